// ===== hdl/lsw_pkg.sv =====
// shared types, constants and the segment lookup for the serial led writer
package lsw_pkg;

	// slot counting for one request
	localparam int SlotW          = 6;
	localparam int FrameSlots     = 24;
	localparam int StartSlots     = 4;
	localparam int StopOneByte    = 20;
	localparam int StopTwoBytes   = 36;
	localparam int LastCtlSlot    = 47;
	localparam int LastDigitSlot  = 63;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DISPLAY_ON   = 3'd0,
		REG_BRIGHTNESS   = 3'd1,
		REG_MODE_BYTE    = 3'd2,
		REG_DATA_BYTE    = 3'd3,
		REG_ADDRESS_BASE = 3'd4,
		REG_CONTROL_BASE = 3'd5
	} reg_index_t;

	// request kinds
	typedef enum logic {
		CMD_CONTROL = 1'b0,
		CMD_DIGIT   = 1'b1
	} command_t;

	// which byte the shifter takes on a load
	typedef enum logic [1:0] {
		SEL_FIRST  = 2'd0,
		SEL_SECOND = 2'd1,
		SEL_THIRD  = 2'd2
	} byte_sel_t;

	// shifter control from the sequencer
	typedef struct packed {
		logic      load;
		logic      shift;
		byte_sel_t sel;
	} shift_ctl_t;

	// line levels for one slot
	typedef struct packed {
		logic strobe;
		logic clk;
		logic dio;
	} pins_t;

	localparam logic [7:0] DotMask = 8'h80;

	// 7-segment pattern, blank above nine
	function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
		logic [7:0] pat;
		unique case (digit)
			4'd0:    pat = 8'h3F;
			4'd1:    pat = 8'h06;
			4'd2:    pat = 8'h5B;
			4'd3:    pat = 8'h4F;
			4'd4:    pat = 8'h66;
			4'd5:    pat = 8'h6D;
			4'd6:    pat = 8'h7D;
			4'd7:    pat = 8'h07;
			4'd8:    pat = 8'h7F;
			4'd9:    pat = 8'h6F;
			default: pat = 8'h00;
		endcase
		return pat;
	endfunction

endpackage

// ===== hdl/lsw_shifter.sv =====
// byte shift register, one bit out at a time, lsb first
module lsw_shifter (
	input  logic               clk,
	input  lsw_pkg::shift_ctl_t ctl,
	input  logic [7:0]         load_byte,
	output logic               bit_out
);
	import lsw_pkg::*;

	logic [7:0] data_q;

	// load a new byte or move the next bit down
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= load_byte;
		end else if (ctl.shift) begin
			data_q <= {1'b0, data_q[7:1]};
		end
	end

	assign bit_out = data_q[0];

endmodule

// ===== hdl/lsw_seq.sv =====
// slot sequencer: counts slots, decodes line levels, holds the output register
module lsw_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                start_cmd,
	output logic                idle,
	input  logic                bit_in,
	output lsw_pkg::shift_ctl_t ctl,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                strobe_pin,
	output logic                clock_pin,
	output logic                data_pin,
	output logic                last
);
	import lsw_pkg::*;

	logic             busy_q;
	command_t         cmd_q;
	logic [SlotW-1:0] slot_q;
	logic             valid_q;
	pins_t            pins_q;
	logic             last_q;

	logic             step;
	logic             second;
	logic             two_bytes;
	logic [SlotW-1:0] f;
	logic [SlotW-1:0] stop_at;
	logic [SlotW-1:0] stop_off;
	logic             in_bits;
	logic             last_slot;
	pins_t            pins_d;

	// advance one slot when the output register is free
	assign step = busy_q && (!valid_q || out_ready);

	// position inside the current frame
	assign second    = slot_q >= SlotW'(FrameSlots);
	assign f         = second ? slot_q - SlotW'(FrameSlots) : slot_q;
	assign two_bytes = second && (cmd_q == CMD_DIGIT);
	assign stop_at   = two_bytes ? SlotW'(StopTwoBytes) : SlotW'(StopOneByte);
	assign stop_off  = f - stop_at;
	assign in_bits   = (f >= SlotW'(StartSlots)) && (f < stop_at);
	assign last_slot = slot_q == ((cmd_q == CMD_DIGIT) ? SlotW'(LastDigitSlot)
		: SlotW'(LastCtlSlot));

	// line levels for this slot
	always_comb begin
		pins_d = '1;
		if (f < SlotW'(StartSlots)) begin
			unique case (f[1:0])
				2'd0:    pins_d = '{strobe: 1'b1, clk: 1'b1, dio: 1'b1};
				2'd1:    pins_d = '{strobe: 1'b1, clk: 1'b1, dio: 1'b1};
				2'd2:    pins_d = '{strobe: 1'b0, clk: 1'b1, dio: 1'b0};
				default: pins_d = '{strobe: 1'b0, clk: 1'b0, dio: 1'b0};
			endcase
		end else if (in_bits) begin
			pins_d = '{strobe: 1'b0, clk: f[0], dio: bit_in};
		end else begin
			unique case (stop_off[1:0])
				2'd0:    pins_d = '{strobe: 1'b1, clk: 1'b0, dio: 1'b0};
				2'd1:    pins_d = '{strobe: 1'b1, clk: 1'b1, dio: 1'b0};
				default: pins_d = '{strobe: 1'b1, clk: 1'b1, dio: 1'b1};
			endcase
		end
	end

	// shifter control: load before the first bit and between the two bytes
	always_comb begin
		ctl.load  = step && ((f == SlotW'(StartSlots - 1))
			|| (two_bytes && f == SlotW'(StopOneByte - 1)));
		ctl.shift = step && in_bits && f[0] && !ctl.load;
		if (f == SlotW'(StartSlots - 1)) begin
			ctl.sel = second ? SEL_SECOND : SEL_FIRST;
		end else begin
			ctl.sel = SEL_THIRD;
		end
	end

	// request and slot tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cmd_q  <= CMD_CONTROL;
			slot_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cmd_q  <= command_t'(start_cmd);
			slot_q <= '0;
		end else if (step) begin
			if (last_slot) begin
				busy_q <= 1'b0;
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + SlotW'(1);
			end
		end
	end

	// output register, lines idle high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pins_q  <= '1;
			last_q  <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
			pins_q  <= pins_d;
			last_q  <= last_slot;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign idle       = !busy_q;
	assign out_valid  = valid_q;
	assign strobe_pin = pins_q.strobe;
	assign clock_pin  = pins_q.clk;
	assign data_pin   = pins_q.dio;
	assign last       = last_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("request taken while busy");
	a_load_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.load && ctl.shift)) else $error("load and shift together");
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_slot) |=> (!busy_q && valid_q && last_q))
		else $error("final slot did not end the request");
	a_ctl_len: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cmd_q == CMD_CONTROL) |-> (slot_q <= SlotW'(LastCtlSlot)))
		else $error("control request ran past its length");
`endif

endmodule

// ===== hdl/led_segment_serial_writer.sv =====
// Strobe/clock/data serial led driver, one line-level result per slot.
// A control request gives 48 results, a digit request 64, one per cycle while
// out_ready is high; the accept sets the sequencer busy, and the first result
// is then registered in the output register. One request at a time: the slot
// counter in the sequencer holds in_ready low until the final slot is registered,
// so a new request is taken only once the last one is through. Reset: lines idle high, no result.
module led_segment_serial_writer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [3:0] position,
	input  logic [3:0] digit,
	input  logic [1:0] dot,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       strobe_pin,
	output logic       clock_pin,
	output logic       data_pin,
	output logic       last,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import lsw_pkg::*;

	logic       display_on_q;
	logic [3:0] brightness_q;
	logic [7:0] mode_byte_q;
	logic [7:0] data_byte_q;
	logic [7:0] address_base_q;
	logic [7:0] control_base_q;

	logic       cmd_q;
	logic [3:0] position_q;
	logic [3:0] digit_q;
	logic [1:0] dot_q;

	logic       idle;
	logic       start;
	logic       shift_bit;
	shift_ctl_t ctl;
	logic [2:0] bri;
	logic [7:0] ctl_byte;
	logic [7:0] seg_byte;
	logic [7:0] load_byte;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_on_q   <= 1'b1;
			brightness_q   <= 4'd7;
			mode_byte_q    <= 8'd3;
			data_byte_q    <= 8'd68;
			address_base_q <= 8'd192;
			control_base_q <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DISPLAY_ON:   display_on_q   <= cfg_data[0];
				REG_BRIGHTNESS:   brightness_q   <= cfg_data[3:0];
				REG_MODE_BYTE:    mode_byte_q    <= cfg_data;
				REG_DATA_BYTE:    data_byte_q    <= cfg_data;
				REG_ADDRESS_BASE: address_base_q <= cfg_data;
				REG_CONTROL_BASE: control_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = idle;
	assign start    = in_valid && idle;

	// request capture
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q      <= command;
			position_q <= position;
			digit_q    <= digit;
			dot_q      <= dot;
		end
	end

	// frame bytes; brightness saturates at seven
	assign bri      = brightness_q[3] ? 3'd7 : brightness_q[2:0];
	assign ctl_byte = control_base_q | {4'b0, display_on_q, bri};

	always_comb begin
		seg_byte = seg_pattern(digit_q);
		if ((dot_q == 2'd1 && position_q == 4'd2) || (dot_q == 2'd2 && position_q == 4'd0)) begin
			seg_byte = seg_byte | DotMask;
		end
	end

	// byte for the next load
	always_comb begin
		unique case (ctl.sel)
			SEL_FIRST:  load_byte = (cmd_q == CMD_DIGIT) ? data_byte_q : mode_byte_q;
			SEL_SECOND: load_byte = (cmd_q == CMD_DIGIT)
				? (address_base_q | {4'b0, position_q}) : ctl_byte;
			default:    load_byte = seg_byte;
		endcase
	end

	lsw_shifter u_shifter (
		.clk       (clk),
		.ctl       (ctl),
		.load_byte (load_byte),
		.bit_out   (shift_bit)
	);

	lsw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.start_cmd  (command),
		.idle       (idle),
		.bit_in     (shift_bit),
		.ctl        (ctl),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.strobe_pin (strobe_pin),
		.clock_pin  (clock_pin),
		.data_pin   (data_pin),
		.last       (last)
	);

endmodule

// ===== test/led_segment_serial_writer_tb.sv =====
// self-checking testbench for the strobe/clock/data serial led writer
module led_segment_serial_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsw_pkg::*;

	localparam int CycleLimit     = 2_000_000;
	localparam int LatencySlack   = 80;
	localparam int PhaseRequests  = 60;
	localparam int RandomPhases   = 8;
	localparam int DigitBlankFrom = 10;
	localparam logic [2:0] BrightMax = 3'd7;
	localparam logic [7:0] OnBit     = 8'h08;
	localparam logic [1:0] DotAtPos2 = 2'd1;
	localparam logic [1:0] DotAtPos0 = 2'd2;
	localparam logic [3:0] DotPosA   = 4'd2;
	localparam logic [3:0] DotPosB   = 4'd0;
	localparam logic [7:0] SegmentCodes [0:9] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	// one expected slot on the lines
	typedef struct packed {
		pins_t pins;
		logic  last;
	} slot_expect_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       command;
	logic [3:0] position;
	logic [3:0] digit;
	logic [1:0] dot;
	logic       out_valid;
	logic       out_ready;
	logic       strobe_pin;
	logic       clock_pin;
	logic       data_pin;
	logic       last;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	// register shadows
	logic       disp_on;
	logic [3:0] bright_level;
	logic [7:0] mode_cmd;
	logic [7:0] data_cmd;
	logic [7:0] addr_base;
	logic [7:0] ctl_base;

	// line state carried across requests
	pins_t line_levels;
	int    slot_idx;
	int    slot_total;

	slot_expect_t pending_slots[$];

	int error_count     = 0;
	int results_checked = 0;
	int control_sent    = 0;
	int digit_sent      = 0;
	int reg_writes      = 0;
	int cycle_count     = 0;
	int tx_gap_max      = 0;
	int rx_stall_max    = 0;
	int rx_hold_cycles  = 0;

	led_segment_serial_writer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.position   (position),
		.digit      (digit),
		.dot        (dot),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.strobe_pin (strobe_pin),
		.clock_pin  (clock_pin),
		.data_pin   (data_pin),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("** led_segment_serial_writer: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------- line model

	function automatic void emit_slot();
		slot_expect_t s;
		s.pins = line_levels;
		s.last = (slot_idx == slot_total - 1);
		pending_slots.push_back(s);
		slot_idx++;
	endfunction

	// start condition: clock and data up, strobe and data down, clock down
	function automatic void frame_open();
		line_levels.clk = 1'b1;
		emit_slot();
		line_levels.dio = 1'b1;
		emit_slot();
		line_levels.strobe = 1'b0;
		line_levels.dio = 1'b0;
		emit_slot();
		line_levels.clk = 1'b0;
		emit_slot();
	endfunction

	// lsb first, data slot then clock-high slot per bit
	function automatic void shift_byte_out(logic [7:0] b);
		for (int i = 0; i < 8; i++) begin
			line_levels.dio = b[i];
			emit_slot();
			line_levels.clk = 1'b1;
			emit_slot();
			line_levels.clk = 1'b0;
		end
	endfunction

	// stop condition plus one idle slot
	function automatic void frame_close();
		line_levels.strobe = 1'b1;
		line_levels.dio = 1'b0;
		emit_slot();
		line_levels.clk = 1'b1;
		emit_slot();
		line_levels.dio = 1'b1;
		emit_slot();
		emit_slot();
	endfunction

	function automatic logic [7:0] segment_byte(logic [3:0] dig, logic [3:0] pos,
			logic [1:0] dt);
		logic [7:0] seg;
		seg = (dig < DigitBlankFrom) ? SegmentCodes[dig] : 8'h00;
		if ((dt == DotAtPos2 && pos == DotPosA) || (dt == DotAtPos0 && pos == DotPosB))
			seg = seg | DotMask;
		return seg;
	endfunction

	// queue every slot that one request produces
	function automatic void predict_transaction(command_t cmd, logic [3:0] pos,
			logic [3:0] dig, logic [1:0] dt);
		logic [2:0] bri;
		logic [7:0] ctl;
		slot_idx = 0;
		if (cmd == CMD_CONTROL) begin
			slot_total = LastCtlSlot + 1;
			bri = (bright_level > BrightMax) ? BrightMax : bright_level[2:0];
			ctl = ctl_base | (disp_on ? OnBit : 8'h00) | {5'b0, bri};
			frame_open();
			shift_byte_out(mode_cmd);
			frame_close();
			frame_open();
			shift_byte_out(ctl);
			frame_close();
		end else begin
			slot_total = LastDigitSlot + 1;
			frame_open();
			shift_byte_out(data_cmd);
			frame_close();
			frame_open();
			shift_byte_out(addr_base | {4'b0, pos});
			shift_byte_out(segment_byte(dig, pos, dt));
			frame_close();
		end
	endfunction

	// ---------------------------------------------------------------- result side

	function automatic void check_line(string field, logic want_v, logic got_v);
		if (got_v !== want_v) begin
			error_count++;
			$display("%0t: %s expected %0b got %0b", $time, field, want_v, got_v);
		end
	endfunction

	// compare each accepted slot with the oldest expectation
	always @(posedge clk) begin
		slot_expect_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			results_checked++;
			if (pending_slots.size() == 0) begin
				error_count++;
				$display("%0t: unexpected slot, nothing expected: strobe %0b clock %0b data %0b last %0b",
					$time, strobe_pin, clock_pin, data_pin, last);
			end else begin
				want = pending_slots.pop_front();
				check_line("strobe_pin", want.pins.strobe, strobe_pin);
				check_line("clock_pin", want.pins.clk, clock_pin);
				check_line("data_pin", want.pins.dio, data_pin);
				check_line("last", want.last, last);
			end
		end
	end

	// receiver: random stall per slot, plus a long hold-off on request
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				out_ready = 1'b0;
				repeat (rx_hold_cycles) @(negedge clk);
				rx_hold_cycles = 0;
			end
			stall = $urandom_range(0, rx_stall_max);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
		end
	end

	// ---------------------------------------------------------------- request side

	task automatic send_request(command_t cmd, logic [3:0] pos, logic [3:0] dig,
			logic [1:0] dt);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		command  = cmd;
		position = pos;
		digit    = dig;
		dot      = dt;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		predict_transaction(cmd, pos, dig, dt);
		if (cmd == CMD_CONTROL)
			control_sent++;
		else
			digit_sent++;
	endtask

	task automatic random_request();
		logic [3:0] pos;
		if ($urandom_range(0, 3) == 0)
			pos = $urandom_range(0, 1) ? DotPosA : DotPosB;
		else
			pos = 4'($urandom_range(0, 15));
		send_request(command_t'($urandom_range(0, 1)), pos, 4'($urandom_range(0, 15)),
			2'($urandom_range(0, 3)));
	endtask

	// drop valid and wait for every expected slot
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_slots.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_DISPLAY_ON:   disp_on      = value[0];
			REG_BRIGHTNESS:   bright_level = value[3:0];
			REG_MODE_BYTE:    mode_cmd     = value;
			REG_DATA_BYTE:    data_cmd     = value;
			REG_ADDRESS_BASE: addr_base    = value;
			REG_CONTROL_BASE: ctl_base     = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic write_all_regs(logic [7:0] on_v, logic [7:0] bri_v, logic [7:0] mode_v,
			logic [7:0] data_v, logic [7:0] addr_v, logic [7:0] ctl_v);
		write_reg(REG_DISPLAY_ON, on_v);
		write_reg(REG_BRIGHTNESS, bri_v);
		write_reg(REG_MODE_BYTE, mode_v);
		write_reg(REG_DATA_BYTE, data_v);
		write_reg(REG_ADDRESS_BASE, addr_v);
		write_reg(REG_CONTROL_BASE, ctl_v);
	endtask

	// ---------------------------------------------------------------- tests

	// default registers: every digit, blanks, and the dot rules
	task automatic test_reset_defaults();
		tx_gap_max   = 3;
		rx_stall_max = 3;
		send_request(CMD_CONTROL, 4'd0, 4'd0, 2'd0);
		for (int d = 0; d < DigitBlankFrom; d++)
			send_request(CMD_DIGIT, 4'(d), 4'(d), 2'd0);
		// blank digits, one still with its dot lit
		send_request(CMD_DIGIT, 4'd3, 4'd10, 2'd0);
		send_request(CMD_DIGIT, DotPosA, 4'd15, DotAtPos2);
		send_request(CMD_DIGIT, DotPosB, 4'd8, DotAtPos0);
		// dot requests at the wrong position stay dark
		send_request(CMD_DIGIT, DotPosB, 4'd1, DotAtPos2);
		send_request(CMD_DIGIT, DotPosA, 4'd1, DotAtPos0);
		send_request(CMD_DIGIT, DotPosA, 4'd7, 2'd3);
		// position above seven goes into the address unchanged
		send_request(CMD_DIGIT, 4'd15, 4'd9, 2'd3);
		wait_results_drained();
	endtask

	// register extremes, brightness saturation, unused indexes
	task automatic test_register_extremes();
		write_all_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(CMD_CONTROL, 4'd0, 4'd0, 2'd0);
		send_request(CMD_DIGIT, 4'd15, 4'd8, DotAtPos2);
		wait_results_drained();
		write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_request(CMD_CONTROL, 4'd15, 4'd15, 2'd3);
		send_request(CMD_DIGIT, 4'd0, 4'd0, 2'd0);
		wait_results_drained();
		// brightness just above and at the saturation point
		write_reg(REG_DISPLAY_ON, 8'hFE);
		write_reg(REG_BRIGHTNESS, 8'h08);
		write_reg(REG_CONTROL_BASE, 8'h40);
		send_request(CMD_CONTROL, 4'd0, 4'd0, 2'd0);
		wait_results_drained();
		write_reg(REG_DISPLAY_ON, 8'h01);
		write_reg(REG_BRIGHTNESS, 8'h07);
		send_request(CMD_CONTROL, 4'd0, 4'd0, 2'd0);
		wait_results_drained();
		// writes beyond the register list change nothing
		for (int i = int'(REG_CONTROL_BASE) + 1; i < 8; i++)
			write_reg(3'(i), 8'($urandom_range(0, 255)));
		send_request(CMD_CONTROL, 4'd0, 4'd0, 2'd0);
		send_request(CMD_DIGIT, DotPosB, 4'd2, DotAtPos0);
		wait_results_drained();
	endtask

	// random requests over several register settings and idle patterns
	task automatic test_random_traffic();
		for (int phase = 0; phase < RandomPhases; phase++) begin
			case (phase % 4)
				0: begin tx_gap_max = 12; rx_stall_max = 12; end
				1: begin tx_gap_max = 0;  rx_stall_max = 12; end
				2: begin tx_gap_max = 12; rx_stall_max = 0;  end
				default: begin tx_gap_max = 0; rx_stall_max = 0; end
			endcase
			if (phase == 2)
				write_all_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			else if (phase == 5)
				write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
			else
				write_all_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			repeat (PhaseRequests) random_request();
			wait_results_drained();
		end
	endtask

	// long receiver hold-off fills the block and stalls its input
	task automatic test_output_backpressure();
		tx_gap_max     = 0;
		rx_stall_max   = 0;
		rx_hold_cycles = 400;
		repeat (6) random_request();
		// sender pauses until every slot is out
		wait_results_drained();
		tx_gap_max   = 12;
		rx_stall_max = 12;
		repeat (4) random_request();
		wait_results_drained();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = CMD_CONTROL;
		position     = 4'd0;
		digit        = 4'd0;
		dot          = 2'd0;
		cfg_we       = 1'b0;
		cfg_index    = REG_DISPLAY_ON;
		cfg_data     = 8'h00;
		disp_on      = 1'b1;
		bright_level = 4'd7;
		mode_cmd     = 8'd3;
		data_cmd     = 8'd68;
		addr_base    = 8'd192;
		ctl_base     = 8'd128;
		line_levels  = '{strobe: 1'b1, clk: 1'b1, dio: 1'b1};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_random_traffic();
		test_output_backpressure();

		wait_results_drained();
		repeat (LatencySlack) @(posedge clk);

		$display("covered %0d control and %0d digit requests, %0d slots checked",
			control_sent, digit_sent, results_checked);
		$display("%0d register writes incl. extremes and unused indexes, %0d mismatches",
			reg_writes, error_count);
		if (error_count == 0 && pending_slots.size() == 0)
			$display("** led_segment_serial_writer: PASSED **");
		else
			$display("** led_segment_serial_writer: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lsw_pkg.sv
hdl/lsw_shifter.sv
hdl/lsw_seq.sv
hdl/led_segment_serial_writer.sv
test/led_segment_serial_writer_tb.sv
